[src/tgc_pkg.sv]
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int COORD_BITS = 12;
   localparam int POS_BITS = 12;
   localparam int DELTA_BITS = 13;
   localparam int HOLDOFF_BITS = 16;
   localparam int THRESH_BITS = 12;
   localparam int TIME_BITS = 32;
   localparam int SUM_BITS = ((COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS) + 2;
   localparam int DELTA_LIMIT = 4095;

   localparam int REQ_TDATA_BITS = 56;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 40;
   localparam int RSP_TUSER_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [SUM_BITS-1:0] diff_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_TAP    = 2'd1,
      EV_HSWIPE = 2'd2,
      EV_VSWIPE = 2'd3
   } event_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TAP_HOLDOFF = 3'd0,
      REG_SWIPE_X_MIN = 3'd1,
      REG_SWIPE_Y_MIN = 3'd2,
      REG_AXIS_MARGIN = 3'd3,
      REG_TAP_SLOP    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                    touch_down;
      logic                    scroll_mode;
      coord_type               pos_x;
      coord_type               pos_y;
      logic [TIME_BITS-1:0]    now_ms;
   } sample_type;

   typedef struct packed {
      logic [HOLDOFF_BITS-1:0] tap_holdoff_ms;
      logic [THRESH_BITS-1:0]  swipe_x_min;
      logic [THRESH_BITS-1:0]  swipe_y_min;
      logic [THRESH_BITS-1:0]  axis_margin;
      logic [THRESH_BITS-1:0]  tap_slop;
   } cfg_type;

   typedef struct packed {
      logic                    was_pressed;
      logic                    gesture_taken;
      coord_type               origin_x;
      coord_type               origin_y;
      coord_type               recent_x;
      coord_type               recent_y;
      logic [TIME_BITS-1:0]    last_gesture_ms;
   } state_type;

   typedef struct packed {
      event_kind_type              kind;
      logic [POS_BITS-1:0]         event_x;
      logic [POS_BITS-1:0]         event_y;
      logic signed [DELTA_BITS-1:0] swipe_delta;
   } result_type;

   function automatic logic signed [DELTA_BITS-1:0] sat_delta(input diff_type d);
      diff_type lim_hi;
      diff_type lim_lo;
      diff_type clipped;
      lim_hi = SUM_BITS'(DELTA_LIMIT);
      lim_lo = -lim_hi;
      if (d > lim_hi) begin
         clipped = lim_hi;
      end else if (d < lim_lo) begin
         clipped = lim_lo;
      end else begin
         clipped = d;
      end
      return clipped[DELTA_BITS-1:0];
   endfunction

   function automatic diff_type abs_diff(input diff_type d);
      return d[SUM_BITS-1] ? -d : d;
   endfunction

endpackage

[src/touch_gesture_classifier_core.sv]
// Flow: a word accepted on req is held in the input register, moves into the result
// register once that register is empty or being taken, and is then offered on rsp.
// Throughput: one word per cycle; the input stalls only while both registers
// hold a word and rsp_tready is low.
// Reset: synchronous and active high; clears both registers' valid flags and the
// press state, and loads the default thresholds.
`timescale 1ns / 1ps

module touch_gesture_classifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x[11:0], pos_y[23:12], now_ms[55:24]
   input  logic [tgc_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // touch_down[0], scroll_mode[1]
   input  logic [tgc_pkg::REQ_TUSER_BITS-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // event_x[11:0], event_y[23:12], swipe_delta[36:24], zero[39:37]
   output logic [tgc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // event_kind[1:0]
   output logic [tgc_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tgc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tgc_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   sample_type sample_ff;
   sample_type sample_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;
   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_calc;
   result_type result_calc;
   logic       advance;
   logic       req_accept;

   tgc_classify u_classify (
      .smp     (sample_ff),
      .cfg     (cfg_ff),
      .st      (state_ff),
      .st_next (state_calc),
      .res     (result_calc)
   );

   always_comb begin
      advance = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_accept = req_tvalid && req_tready;
      csr_ready = 1'b1;

      in_valid_in = req_accept || (in_valid_ff && !advance);
      sample_in = sample_ff;
      if (req_accept) begin
         sample_in.touch_down = req_tuser[0];
         sample_in.scroll_mode = req_tuser[1];
         sample_in.pos_x = COORD_BITS'(req_tdata[11:0]);
         sample_in.pos_y = COORD_BITS'(req_tdata[23:12]);
         sample_in.now_ms = req_tdata[55:24];
      end

      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      result_in = advance ? result_calc : result_ff;
      state_in = advance ? state_calc : state_ff;

      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TAP_HOLDOFF: cfg_in.tap_holdoff_ms = csr_wdata;
            REG_SWIPE_X_MIN: cfg_in.swipe_x_min = csr_wdata[THRESH_BITS-1:0];
            REG_SWIPE_Y_MIN: cfg_in.swipe_y_min = csr_wdata[THRESH_BITS-1:0];
            REG_AXIS_MARGIN: cfg_in.axis_margin = csr_wdata[THRESH_BITS-1:0];
            REG_TAP_SLOP:    cfg_in.tap_slop = csr_wdata[THRESH_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
         cfg_ff.tap_holdoff_ms <= HOLDOFF_BITS'(160);
         cfg_ff.swipe_x_min <= THRESH_BITS'(55);
         cfg_ff.swipe_y_min <= THRESH_BITS'(40);
         cfg_ff.axis_margin <= THRESH_BITS'(8);
         cfg_ff.tap_slop <= THRESH_BITS'(20);
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
         cfg_ff <= cfg_in;
      end
      sample_ff <= sample_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = result_ff.kind;
   assign rsp_tdata = {3'b000, result_ff.swipe_delta, result_ff.event_y, result_ff.event_x};

`ifndef SYNTH
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.kind == EV_NONE |-> rsp_tdata == '0)
      else $error("empty result word carries nonzero data");

   a_tap_no_delta: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.kind == EV_TAP |-> result_ff.swipe_delta == '0)
      else $error("tap word carries a swipe delta");

   a_swipe_no_pos: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (result_ff.kind == EV_HSWIPE || result_ff.kind == EV_VSWIPE)
      |-> result_ff.event_x == '0 && result_ff.event_y == '0)
      else $error("swipe word carries a tap position");

   a_taken_needs_press: assert property (@(posedge clock) disable iff (reset)
      state_ff.gesture_taken |-> state_ff.was_pressed)
      else $error("gesture marked taken outside a press");

   a_gesture_time: assert property (@(posedge clock) disable iff (reset)
      advance && result_calc.kind != EV_NONE
      |=> state_ff.last_gesture_ms == $past(sample_ff.now_ms))
      else $error("gesture time not recorded");
`endif

endmodule

[src/tgc_classify.sv]
`timescale 1ns / 1ps

module tgc_classify (
   input  tgc_pkg::sample_type smp,
   input  tgc_pkg::cfg_type    cfg,
   input  tgc_pkg::state_type  st,
   output tgc_pkg::state_type  st_next,
   output tgc_pkg::result_type res
);
   import tgc_pkg::*;

   diff_type dx;
   diff_type dy;
   diff_type ax;
   diff_type ay;
   diff_type rx;
   diff_type ry;
   logic     holdoff_ok;
   logic     h_swipe;
   logic     v_swipe;
   logic     slop_ok;

   always_comb begin
      dx = diff_type'(smp.pos_x) - diff_type'(st.origin_x);
      dy = diff_type'(smp.pos_y) - diff_type'(st.origin_y);
      ax = abs_diff(dx);
      ay = abs_diff(dy);
      rx = abs_diff(diff_type'(st.recent_x) - diff_type'(st.origin_x));
      ry = abs_diff(diff_type'(st.recent_y) - diff_type'(st.origin_y));

      holdoff_ok = (smp.now_ms - st.last_gesture_ms) > TIME_BITS'(cfg.tap_holdoff_ms);
      h_swipe = (ax > diff_type'(cfg.swipe_x_min))
                && (ax > ay + diff_type'(cfg.axis_margin));
      v_swipe = (ay > diff_type'(cfg.swipe_y_min))
                && (ay > ax + diff_type'(cfg.axis_margin));
      slop_ok = (rx < diff_type'(cfg.tap_slop)) && (ry < diff_type'(cfg.tap_slop));

      st_next = st;
      res = '0;

      if (smp.touch_down) begin
         st_next.recent_x = smp.pos_x;
         st_next.recent_y = smp.pos_y;
         if (!st.was_pressed) begin
            st_next.was_pressed = 1'b1;
            st_next.gesture_taken = 1'b0;
            st_next.origin_x = smp.pos_x;
            st_next.origin_y = smp.pos_y;
            if (!smp.scroll_mode && holdoff_ok) begin
               res.kind = EV_TAP;
               res.event_x = POS_BITS'(smp.pos_x);
               res.event_y = POS_BITS'(smp.pos_y);
               st_next.gesture_taken = 1'b1;
               st_next.last_gesture_ms = smp.now_ms;
            end
         end else if (!st.gesture_taken) begin
            if (h_swipe) begin
               res.kind = EV_HSWIPE;
               res.swipe_delta = sat_delta(dx);
               st_next.gesture_taken = 1'b1;
               st_next.last_gesture_ms = smp.now_ms;
            end else if (v_swipe) begin
               res.kind = EV_VSWIPE;
               res.swipe_delta = sat_delta(dy);
               st_next.gesture_taken = 1'b1;
               st_next.last_gesture_ms = smp.now_ms;
            end
         end
      end else begin
         if (st.was_pressed && !st.gesture_taken && smp.scroll_mode && holdoff_ok
             && slop_ok) begin
            res.kind = EV_TAP;
            res.event_x = POS_BITS'(st.origin_x);
            res.event_y = POS_BITS'(st.origin_y);
            st_next.last_gesture_ms = smp.now_ms;
         end
         st_next.was_pressed = 1'b0;
         st_next.gesture_taken = 1'b0;
      end
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import tgc_pkg::*;

   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 240;
   localparam int SINK_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int COORD_MAX = 4095;

   class gesture_tracker;
      cfg_type     cfg;
      state_type   press;
      result_type  expected_events[$];
      int unsigned mismatches;
      int unsigned words_checked;
      int unsigned taps;
      int unsigned hswipes;
      int unsigned vswipes;

      function new();
         cfg = '{tap_holdoff_ms: 16'd160, swipe_x_min: 12'd55, swipe_y_min: 12'd40,
                 axis_margin: 12'd8, tap_slop: 12'd20};
         press = '0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] idx,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_TAP_HOLDOFF: cfg.tap_holdoff_ms = value;
            REG_SWIPE_X_MIN: cfg.swipe_x_min = value[THRESH_BITS-1:0];
            REG_SWIPE_Y_MIN: cfg.swipe_y_min = value[THRESH_BITS-1:0];
            REG_AXIS_MARGIN: cfg.axis_margin = value[THRESH_BITS-1:0];
            REG_TAP_SLOP:    cfg.tap_slop = value[THRESH_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit holdoff_over(logic [TIME_BITS-1:0] now);
         logic [TIME_BITS-1:0] elapsed;
         elapsed = now - press.last_gesture_ms;
         return elapsed > {16'd0, cfg.tap_holdoff_ms};
      endfunction

      function logic signed [DELTA_BITS-1:0] clip_delta(int d);
         if (d > DELTA_LIMIT) begin
            d = DELTA_LIMIT;
         end else if (d < -DELTA_LIMIT) begin
            d = -DELTA_LIMIT;
         end
         return DELTA_BITS'(d);
      endfunction

      function void take_touch(sample_type t);
         result_type r;
         int dx;
         int dy;
         int ax;
         int ay;
         r = '0;
         r.kind = EV_NONE;
         if (t.touch_down) begin
            press.recent_x = t.pos_x;
            press.recent_y = t.pos_y;
            if (!press.was_pressed) begin
               press.was_pressed = 1'b1;
               press.gesture_taken = 1'b0;
               press.origin_x = t.pos_x;
               press.origin_y = t.pos_y;
               if (!t.scroll_mode && holdoff_over(t.now_ms)) begin
                  r.kind = EV_TAP;
                  r.event_x = t.pos_x;
                  r.event_y = t.pos_y;
                  press.gesture_taken = 1'b1;
                  press.last_gesture_ms = t.now_ms;
               end
            end else if (!press.gesture_taken) begin
               dx = int'(t.pos_x) - int'(press.origin_x);
               dy = int'(t.pos_y) - int'(press.origin_y);
               ax = (dx < 0) ? -dx : dx;
               ay = (dy < 0) ? -dy : dy;
               if (ax > int'(cfg.swipe_x_min) && ax > ay + int'(cfg.axis_margin)) begin
                  r.kind = EV_HSWIPE;
                  r.swipe_delta = clip_delta(dx);
                  press.gesture_taken = 1'b1;
                  press.last_gesture_ms = t.now_ms;
               end else if (ay > int'(cfg.swipe_y_min) &&
                            ay > ax + int'(cfg.axis_margin)) begin
                  r.kind = EV_VSWIPE;
                  r.swipe_delta = clip_delta(dy);
                  press.gesture_taken = 1'b1;
                  press.last_gesture_ms = t.now_ms;
               end
            end
         end else begin
            if (press.was_pressed && !press.gesture_taken && t.scroll_mode &&
                holdoff_over(t.now_ms)) begin
               dx = int'(press.recent_x) - int'(press.origin_x);
               dy = int'(press.recent_y) - int'(press.origin_y);
               ax = (dx < 0) ? -dx : dx;
               ay = (dy < 0) ? -dy : dy;
               if (ax < int'(cfg.tap_slop) && ay < int'(cfg.tap_slop)) begin
                  r.kind = EV_TAP;
                  r.event_x = press.origin_x;
                  r.event_y = press.origin_y;
                  press.last_gesture_ms = t.now_ms;
               end
            end
            press.was_pressed = 1'b0;
            press.gesture_taken = 1'b0;
         end
         expected_events.push_back(r);
      endfunction

      task flag_mismatch(string what, int got, int want);
         mismatches++;
         if (mismatches <= 40) begin
            $display("Mismatch on %s in word %0d: got %0d, expected %0d.",
                     what, words_checked, got, want);
         end
      endtask

      task match_event(result_type got);
         result_type want;
         if (expected_events.size() == 0) begin
            flag_mismatch("unexpected word", int'(got.kind), -1);
            return;
         end
         want = expected_events.pop_front();
         words_checked++;
         case (want.kind)
            EV_TAP:    taps++;
            EV_HSWIPE: hswipes++;
            EV_VSWIPE: vswipes++;
            default: ;
         endcase
         if (got.kind != want.kind) flag_mismatch("event_kind", got.kind, want.kind);
         if (got.event_x != want.event_x) flag_mismatch("event_x", got.event_x, want.event_x);
         if (got.event_y != want.event_y) flag_mismatch("event_y", got.event_y, want.event_y);
         if (got.swipe_delta != want.swipe_delta) begin
            flag_mismatch("swipe_delta", int'(got.swipe_delta), int'(want.swipe_delta));
         end
      endtask
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_TDATA_BITS-1:0]   req_tdata;
   logic [REQ_TUSER_BITS-1:0]   req_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic [RSP_TUSER_BITS-1:0]   rsp_tuser;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_wdata;

   gesture_tracker       tracker = new();
   logic [TIME_BITS-1:0] panel_ms;
   int unsigned          words_sent;
   bit                   source_gaps;
   bit                   sink_stalls;
   bit                   sink_hold_due;

   touch_gesture_classifier_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin : watch
      sample_type t;
      result_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            t.touch_down = req_tuser[0];
            t.scroll_mode = req_tuser[1];
            t.pos_x = req_tdata[11:0];
            t.pos_y = req_tdata[23:12];
            t.now_ms = req_tdata[55:24];
            tracker.take_touch(t);
         end
         if (rsp_tvalid && rsp_tready) begin
            r.kind = event_kind_type'(rsp_tuser);
            r.event_x = rsp_tdata[11:0];
            r.event_y = rsp_tdata[23:12];
            r.swipe_delta = rsp_tdata[36:24];
            tracker.match_event(r);
         end
         if (csr_valid && csr_ready) begin
            tracker.set_register(csr_index, csr_wdata);
         end
      end
   end

   function automatic int pick_gap(bit enabled);
      if (!enabled || $urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   initial begin : sink
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (sink_hold_due) begin
            sink_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
         end else begin
            n = pick_gap(sink_stalls);
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic int fit_coord(int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic int signed_draw(int limit);
      int v;
      v = $urandom_range(0, (limit > COORD_MAX) ? COORD_MAX : limit);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [TIME_BITS-1:0] next_ms();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         panel_ms += $urandom_range(0, 40);
      end else if (pick < 96) begin
         panel_ms += $urandom_range(100, 600);
      end else if (pick < 99) begin
         panel_ms += $urandom_range(60000, 70000);
      end else begin
         panel_ms = $urandom;
      end
      return panel_ms;
   endfunction

   function automatic sample_type make_touch(bit down, bit scroll, int x, int y,
                                             logic [TIME_BITS-1:0] at_ms);
      sample_type t;
      t.touch_down = down;
      t.scroll_mode = scroll;
      t.pos_x = coord_type'(fit_coord(x));
      t.pos_y = coord_type'(fit_coord(y));
      t.now_ms = at_ms;
      return t;
   endfunction

   task automatic send_touch(sample_type t);
      int gap;
      gap = pick_gap(source_gaps);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t.now_ms, t.pos_y, t.pos_x};
      req_tuser <= {t.scroll_mode, t.touch_down};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_noise();
      send_touch(make_touch(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            next_ms()));
   endtask

   task automatic send_press();
      int ox;
      int oy;
      int dx;
      int dy;
      int reach;
      int moves;
      int style;
      bit scroll;
      scroll = 1'($urandom_range(0, 1));
      ox = $urandom_range(0, COORD_MAX);
      oy = $urandom_range(0, COORD_MAX);
      style = $urandom_range(0, 3);
      moves = $urandom_range(0, 5);
      send_touch(make_touch(1'b1, scroll, ox, oy, next_ms()));
      repeat (moves) begin
         if ($urandom_range(0, 11) == 0) scroll = ~scroll;
         case (style)
            0: begin
               reach = 2 * int'(tracker.cfg.swipe_x_min) + int'(tracker.cfg.axis_margin) + 16;
               dx = signed_draw(reach);
               dy = signed_draw((dx < 0 ? -dx : dx) / 2 + int'(tracker.cfg.axis_margin) + 2);
            end
            1: begin
               reach = 2 * int'(tracker.cfg.swipe_y_min) + int'(tracker.cfg.axis_margin) + 16;
               dy = signed_draw(reach);
               dx = signed_draw((dy < 0 ? -dy : dy) / 2 + int'(tracker.cfg.axis_margin) + 2);
            end
            2: begin
               dx = signed_draw(int'(tracker.cfg.tap_slop) + 1);
               dy = signed_draw(int'(tracker.cfg.tap_slop) + 1);
            end
            default: begin
               dx = $urandom_range(0, COORD_MAX) - ox;
               dy = $urandom_range(0, COORD_MAX) - oy;
            end
         endcase
         send_touch(make_touch(1'b1, scroll, ox + dx, oy + dy, next_ms()));
      end
      if ($urandom_range(0, 9) != 0) begin
         send_touch(make_touch(1'b0, scroll, $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX), next_ms()));
      end
   endtask

   task automatic drain(int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_events.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic cfg_type phase_settings(int phase);
      cfg_type c;
      case (phase)
         1: c = '0;
         2: c = '1;
         3: begin
            c.tap_holdoff_ms = HOLDOFF_BITS'($urandom);
            c.swipe_x_min = THRESH_BITS'($urandom);
            c.swipe_y_min = THRESH_BITS'($urandom);
            c.axis_margin = THRESH_BITS'($urandom);
            c.tap_slop = THRESH_BITS'($urandom);
         end
         6: begin
            c.tap_holdoff_ms = '0;
            c.swipe_x_min = THRESH_BITS'($urandom_range(0, 30));
            c.swipe_y_min = THRESH_BITS'($urandom_range(0, 30));
            c.axis_margin = THRESH_BITS'($urandom_range(0, 4));
            c.tap_slop = '1;
         end
         default: begin
            c.tap_holdoff_ms = HOLDOFF_BITS'($urandom_range(0, 400));
            c.swipe_x_min = THRESH_BITS'($urandom_range(20, 120));
            c.swipe_y_min = THRESH_BITS'($urandom_range(20, 120));
            c.axis_margin = THRESH_BITS'($urandom_range(0, 30));
            c.tap_slop = THRESH_BITS'($urandom_range(1, 60));
         end
      endcase
      return c;
   endfunction

   task automatic apply_settings(cfg_type c);
      logic [CSR_DATA_BITS-1:0] value;
      for (int i = 0; i < (1 << CSR_INDEX_BITS); i++) begin
         case (i)
            REG_TAP_HOLDOFF: value = c.tap_holdoff_ms;
            REG_SWIPE_X_MIN: value = CSR_DATA_BITS'(c.swipe_x_min);
            REG_SWIPE_Y_MIN: value = CSR_DATA_BITS'(c.swipe_y_min);
            REG_AXIS_MARGIN: value = CSR_DATA_BITS'(c.axis_margin);
            REG_TAP_SLOP:    value = CSR_DATA_BITS'(c.tap_slop);
            default:         value = CSR_DATA_BITS'($urandom);
         endcase
         csr_valid <= 1'b1;
         csr_index <= i[CSR_INDEX_BITS-1:0];
         csr_wdata <= value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int count);
      int unsigned target;
      target = words_sent + count;
      while (words_sent < target) begin
         if ($urandom_range(0, 9) < 2) begin
            send_noise();
         end else begin
            send_press();
         end
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      sink_hold_due = 1'b0;
      words_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed run at the reset thresholds.
      send_touch(make_touch(1'b0, 1'b0, 7, 9, 32'd5));
      send_touch(make_touch(1'b1, 1'b0, 100, 100, 32'd100));
      send_touch(make_touch(1'b1, 1'b0, 156, 100, 32'd110));
      send_touch(make_touch(1'b1, 1'b0, 300, 300, 32'd115));
      send_touch(make_touch(1'b0, 1'b0, 300, 300, 32'd120));
      send_touch(make_touch(1'b1, 1'b0, 4095, 4095, 32'd270));
      send_touch(make_touch(1'b1, 1'b0, 4095, 4050, 32'd275));
      send_touch(make_touch(1'b0, 1'b0, 0, 0, 32'd280));
      send_touch(make_touch(1'b1, 1'b0, 4095, 4095, 32'd436));
      send_touch(make_touch(1'b0, 1'b0, 4095, 4095, 32'd440));
      send_touch(make_touch(1'b1, 1'b0, 4095, 0, 32'd500));
      send_touch(make_touch(1'b1, 1'b0, 4035, 55, 32'd505));
      send_touch(make_touch(1'b1, 1'b0, 0, 100, 32'd510));
      send_touch(make_touch(1'b0, 1'b0, 0, 100, 32'd515));
      send_touch(make_touch(1'b1, 1'b0, 0, 0, 32'd600));
      send_touch(make_touch(1'b1, 1'b0, 0, 4095, 32'd605));
      send_touch(make_touch(1'b0, 1'b0, 0, 4095, 32'd610));
      send_touch(make_touch(1'b1, 1'b1, 100, 100, 32'd800));
      send_touch(make_touch(1'b1, 1'b1, 119, 81, 32'd810));
      send_touch(make_touch(1'b0, 1'b1, 5, 5, 32'd900));
      send_touch(make_touch(1'b1, 1'b1, 500, 500, 32'd1100));
      send_touch(make_touch(1'b1, 1'b1, 520, 500, 32'd1110));
      send_touch(make_touch(1'b0, 1'b1, 520, 500, 32'd1200));
      send_touch(make_touch(1'b1, 1'b0, 2000, 2000, 32'hFFFF_FFF0));
      send_touch(make_touch(1'b0, 1'b0, 2000, 2000, 32'hFFFF_FFF8));
      send_touch(make_touch(1'b1, 1'b0, 10, 20, 32'h0000_0091));
      send_touch(make_touch(1'b0, 1'b0, 10, 20, 32'h0000_0095));
      panel_ms = 32'h0000_0095;
      drain(SETTLE_CYCLES);

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(phase_settings(phase));
         source_gaps = (phase != 3 && phase != 4 && phase != 7);
         sink_stalls = (phase != 2 && phase != 4 && phase != 7);
         if (phase == 4 || phase == 7) sink_hold_due = 1'b1;
         run_phase(PHASE_WORDS);
         drain(SETTLE_CYCLES);
      end
      drain(10);

      $display("Sent %0d touch words through %0d threshold settings, including extremes.",
               words_sent, PHASES + 1);
      $display("Checked %0d results: %0d taps, %0d horizontal and %0d vertical swipes.",
               tracker.words_checked, tracker.taps, tracker.hswipes, tracker.vswipes);
      if (tracker.mismatches == 0 && tracker.expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Timed out with %0d results still outstanding.",
               tracker.expected_events.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
